// ----- sv/sepq_pkg.sv -----
// ----------------------------------------------------------------------------
// sepq_pkg
// Shared types, codes and constants of the speculative echo prediction queue.
// ----------------------------------------------------------------------------
package sepq_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int MAX_COLS_DEF   = 1024;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [20:0] CHAR_SPACE  = 21'h20;
    localparam logic [20:0] CHAR_DEL    = 21'h7F;
    localparam logic [7:0]  BYTE_SPACE  = 8'h20;
    localparam logic [7:0]  BYTE_DEL    = 8'h7F;
    localparam logic [7:0]  BYTE_ASCII  = 8'h80;
    localparam logic [7:0]  UTF8_MASK   = 8'hC0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [1:0]  WIDTH_WIDE  = 2'd2;

    localparam logic [0:0]  REG_ECHO_ON = 1'b0;

    typedef enum logic [1:0] {
        FUNC_KEY      = 2'd0,
        FUNC_ECHO     = 2'd1,
        FUNC_ROLLBACK = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_HALF  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_REJECT   = 2'd0,
        OP_KEY      = 2'd1,
        OP_ECHO     = 2'd2,
        OP_ROLLBACK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_DECIDE = 2'd1,
        BK_HALF   = 2'd2,
        BK_CLEAR  = 2'd3
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic [20:0] code;
        logic [1:0]  width;
        logic [7:0]  row;
        logic [9:0]  ccol;
        logic [10:0] cols;
        logic [7:0]  echo_byte;
    } op_item_t;

    typedef struct packed {
        logic [20:0] code;
        logic [7:0]  row;
        logic [9:0]  col;
        logic [1:0]  width;
    } slot_t;

    typedef struct packed {
        logic        valid;
        action_t     action;
        logic [7:0]  row;
        logic [9:0]  col;
        logic [20:0] code;
        logic [1:0]  width;
        logic        accepted;
        logic        last;
    } res_t;

endpackage

// ----- sv/sepq_queue.sv -----
// ----------------------------------------------------------------------------
// sepq_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module sepq_queue
    import sepq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  op_item_t din,
    input  logic     pop,
    output op_item_t dout,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    op_item_t          store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- sv/sepq_front.sv -----
// ----------------------------------------------------------------------------
// sepq_front
// Register port and input classifier: screens keys and echo bytes, queues
// the operations for the back end.
// ----------------------------------------------------------------------------
module sepq_front
    import sepq_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  reg_index,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  logic        start,
    input  logic [1:0]  func,
    input  logic [20:0] codepoint,
    input  logic [1:0]  char_width,
    input  logic [7:0]  echo_byte,
    input  logic [2:0]  mode_flags,
    input  logic [7:0]  cur_row,
    input  logic [9:0]  cur_col,
    input  logic [10:0] screen_cols,
    input  logic        queue_full,
    output logic        push,
    output op_item_t    item
);

    localparam logic [12:0] MAX_COLS_W = 13'(MAX_COLS);

    logic  echo_on_reg;
    logic  key_ok;
    logic  byte_skip;
    logic  keep;
    func_t fn;

    assign fn = func_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_on_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (reg_index == REG_ECHO_ON))
        begin
            echo_on_reg <= pwdata[0];
        end
    end

    assign prdata = (reg_index == REG_ECHO_ON) ? {31'd0, echo_on_reg} : 32'd0;

    assign key_ok = echo_on_reg && !mode_flags[0] && mode_flags[1] && !mode_flags[2]
                    && (codepoint >= CHAR_SPACE) && (codepoint != CHAR_DEL);

    assign byte_skip = (echo_byte < BYTE_SPACE) || (echo_byte == BYTE_DEL)
                       || ((echo_byte & UTF8_MASK) == UTF8_CONT);

    always_comb
    begin
        item.code      = codepoint;
        item.width     = char_width;
        item.row       = cur_row;
        item.ccol      = cur_col;
        item.echo_byte = echo_byte;
        item.cols      = ({2'd0, screen_cols} > MAX_COLS_W) ? MAX_COLS_W[10:0] : screen_cols;
        item.op        = OP_REJECT;
        keep           = 1'b0;
        unique case (fn)
            FUNC_KEY:
            begin
                keep    = 1'b1;
                item.op = key_ok ? OP_KEY : OP_REJECT;
            end
            FUNC_ECHO:
            begin
                keep    = !byte_skip;
                item.op = (echo_byte < BYTE_ASCII) ? OP_ECHO : OP_ROLLBACK;
            end
            FUNC_ROLLBACK:
            begin
                keep    = 1'b1;
                item.op = OP_ROLLBACK;
            end
            FUNC_NONE:
            begin
                keep = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = start && !queue_full && keep;

endmodule

// ----- sv/sepq_back.sv -----
// ----------------------------------------------------------------------------
// sepq_back
// Prediction ring engine: records keys, confirms or rolls back predictions,
// drives the registered command output.
// ----------------------------------------------------------------------------
module sepq_back
    import sepq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  op_item_t op_in,
    input  logic     q_empty,
    output logic     pop,
    output res_t     res
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

    slot_t            mem [RING_DEPTH];
    slot_t            rd_reg;
    slot_t            wr_slot;
    logic             mem_we;

    back_state_t      state_reg;
    back_state_t      state_next;
    op_item_t         op_reg;
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    wp_next;
    logic [PW-1:0]    rp_reg;
    logic [PW-1:0]    rp_next;
    logic [10:0]      pw_reg;
    logic [10:0]      pw_next;
    logic             clear_one_reg;
    logic             clear_one_next;
    logic [9:0]       half_col_reg;
    logic [9:0]       half_col_next;
    res_t             res_reg;
    res_t             res_next;

    logic [PW-1:0]    wp_inc;
    logic [PW-1:0]    rp_inc;
    logic             ring_full;
    logic             ring_empty;
    logic [11:0]      col_sum;
    logic [12:0]      end_sum;
    logic [12:0]      cols_w;
    logic             key_fit;
    logic             half_ok;
    logic             clear_done;

    assign wp_inc     = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign rp_inc     = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;
    assign ring_full  = (wp_inc == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);
    assign col_sum    = {2'd0, op_reg.ccol} + {1'b0, pw_reg};
    assign end_sum    = {1'b0, col_sum} + {11'd0, op_reg.width};
    assign cols_w     = {2'd0, op_reg.cols};
    assign key_fit    = ({1'b0, col_sum} < cols_w) && (end_sum <= cols_w);
    assign half_ok    = (op_reg.width == WIDTH_WIDE) && (({1'b0, col_sum} + 13'd1) < cols_w);
    assign clear_done = clear_one_reg || (rp_inc == wp_reg);

    assign wr_slot.code  = op_reg.code;
    assign wr_slot.row   = op_reg.row;
    assign wr_slot.col   = col_sum[9:0];
    assign wr_slot.width = op_reg.width;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        pw_next        = pw_reg;
        clear_one_next = clear_one_reg;
        half_col_next  = half_col_reg;
        res_next       = '0;
        pop            = 1'b0;
        mem_we         = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_DECIDE;
                end
            end
            BK_DECIDE:
            begin
                state_next = BK_IDLE;
                unique case (op_reg.op)
                    OP_REJECT:
                    begin
                        res_next.valid = 1'b1;
                        res_next.last  = 1'b1;
                    end
                    OP_KEY:
                    begin
                        res_next.valid = 1'b1;
                        if (ring_full || !key_fit)
                        begin
                            res_next.last = 1'b1;
                        end
                        else
                        begin
                            mem_we            = 1'b1;
                            wp_next           = wp_inc;
                            pw_next           = pw_reg + {9'd0, op_reg.width};
                            res_next.action   = ACT_WRITE;
                            res_next.row      = op_reg.row;
                            res_next.col      = col_sum[9:0];
                            res_next.code     = op_reg.code;
                            res_next.width    = op_reg.width;
                            res_next.accepted = 1'b1;
                            res_next.last     = !half_ok;
                            half_col_next     = col_sum[9:0] + 10'd1;
                            if (half_ok)
                            begin
                                state_next = BK_HALF;
                            end
                        end
                    end
                    OP_ECHO:
                    begin
                        if (!ring_empty)
                        begin
                            clear_one_next = (rd_reg.code == {13'd0, op_reg.echo_byte});
                            state_next     = BK_CLEAR;
                        end
                    end
                    OP_ROLLBACK:
                    begin
                        if (!ring_empty)
                        begin
                            clear_one_next = 1'b0;
                            state_next     = BK_CLEAR;
                        end
                    end
                    default:
                    begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_HALF:
            begin
                res_next.valid    = 1'b1;
                res_next.action   = ACT_HALF;
                res_next.row      = op_reg.row;
                res_next.col      = half_col_reg;
                res_next.accepted = 1'b1;
                res_next.last     = 1'b1;
                state_next        = BK_IDLE;
            end
            BK_CLEAR:
            begin
                res_next.valid  = 1'b1;
                res_next.action = ACT_CLEAR;
                res_next.row    = rd_reg.row;
                res_next.col    = rd_reg.col;
                res_next.last   = clear_done;
                rp_next         = rp_inc;
                pw_next         = pw_reg - {9'd0, rd_reg.width};
                if (clear_done)
                begin
                    state_next = BK_IDLE;
                    if (!clear_one_reg)
                    begin
                        pw_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            pw_reg        <= '0;
            clear_one_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            pw_reg        <= pw_next;
            clear_one_reg <= clear_one_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        half_col_reg <= half_col_next;
        if (pop)
        begin
            op_reg <= op_in;
        end
    end

    // ring storage, registered read at the next read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= wr_slot;
        end
        rd_reg <= mem[rp_next];
    end

    assign res = res_reg;

endmodule

// ----- sv/speculative_echo_prediction_queue_top.sv -----
// ----------------------------------------------------------------------------
// speculative_echo_prediction_queue_top
// Local echo predictor: records typed keys as predicted cells and confirms
// or rolls them back against host echo.
//
// Input: a transaction is taken at a clock edge with start high and busy
// low. busy is high only while the two-entry operation queue is full.
// Output: each command is on the result ports for one cycle with
// result_valid high; last marks the final command of a transaction. The
// receiver cannot stall; no backpressure exists on the output.
// Back end: an accepted wide key is followed by a command for its trailing
// half. A rollback, or an echo that mismatches or is a lead byte, clears
// every pending entry, up to RING_DEPTH-1, walking the ring memory one
// entry per cycle through its single read port; a matching echo clears one
// entry. Skipped echo bytes and unused codes produce nothing and never
// reach the back end.
// Reset: ring empty, pending width zero, echo_on set; no clearing pass.
// Register: echo_on at address 0; the user must write it only while idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module speculative_echo_prediction_queue_top
    import sepq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [20:0] codepoint,
    input  logic [1:0]  char_width,
    input  logic [7:0]  echo_byte,
    input  logic [2:0]  mode_flags,
    input  logic [7:0]  cur_row,
    input  logic [9:0]  cur_col,
    input  logic [10:0] screen_cols,
    output logic        result_valid,
    output logic [1:0]  action,
    output logic [7:0]  cell_row,
    output logic [9:0]  cell_col,
    output logic [20:0] cell_code,
    output logic [1:0]  cell_width,
    output logic        accepted,
    output logic        last
);

    op_item_t push_item;
    op_item_t head_item;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    res_t     res;
    logic     addr_low_unused;

    assign pready          = 1'b1;
    assign busy            = q_full;
    assign addr_low_unused = ^paddr[1:0];

    sepq_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .reg_index   (paddr[2:2]),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .start       (start),
        .func        (func),
        .codepoint   (codepoint),
        .char_width  (char_width),
        .echo_byte   (echo_byte),
        .mode_flags  (mode_flags),
        .cur_row     (cur_row),
        .cur_col     (cur_col),
        .screen_cols (screen_cols),
        .queue_full  (q_full),
        .push        (push),
        .item        (push_item)
    );

    sepq_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_item),
        .pop   (pop),
        .dout  (head_item),
        .full  (q_full),
        .empty (q_empty)
    );

    sepq_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_in   (head_item),
        .q_empty (q_empty),
        .pop     (pop),
        .res     (res)
    );

    assign result_valid = res.valid;
    assign action       = res.action;
    assign cell_row     = res.row;
    assign cell_col     = res.col;
    assign cell_code    = res.code;
    assign cell_width   = res.width;
    assign accepted     = res.accepted;
    assign last         = res.last && !(addr_low_unused && 1'b0);

endmodule
